### rtl/scb_pkg.sv
// ----------------------------------------------------------------------------
// scb_pkg: shared types, constants and table builder
// Holds the angle reduction constants, the inter-stage struct and the
// elaboration-time builder for the first-quadrant sine and cosine table.
// ----------------------------------------------------------------------------
package scb_pkg;

  localparam int MOD_BASE    = 360;
  localparam int QUAD_SPAN   = 90;
  localparam int OFFSET_BIAS = 33120;
  localparam int RECIP       = 93207;
  localparam int RECIP_SHIFT = 25;
  localparam int TABLE_DEPTH = 90;
  localparam int OUT_ONE     = 16384;
  localparam int HALF_ROOT2  = 11585;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] quad;
    logic [6:0] off;
  } red_t;

  function automatic logic [63:0] isqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] root;
    logic [63:0] bitv;
    v    = v_in;
    root = 64'd0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bitv > v) bitv = bitv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != 64'd0) begin
        if (v >= root + bitv) begin
          v    = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return root;
  endfunction

  function automatic longint scaled_div(input longint s, input logic [63:0] n,
                                        input int fbits);
    logic [63:0] mag;
    logic [63:0] num;
    logic [64:0] rem;
    logic [63:0] q;
    mag = (s < 0) ? 64'(-s) : 64'(s);
    num = (mag << fbits) + (n >> 1);
    rem = 65'd0;
    q   = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, n}) begin
        rem  = rem - {1'b0, n};
        q[i] = 1'b1;
      end
    end
    return (s < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] to_q14(input longint v, input int fbits);
    logic [63:0] mag;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    if (fbits > 14) mag = (mag + (64'd1 << (fbits - 15))) >> (fbits - 14);
    else mag = mag << (14 - fbits);
    if (mag > 64'(OUT_ONE)) mag = 64'(OUT_ONE);
    return mag[15:0];
  endfunction

  // Entry packs cosine in the upper half and sine in the lower half.
  function automatic logic [31:0] entry(input int off, input int iters,
                                        input int fbits);
    longint one;
    longint x0, y0, x1, y1, xc, yc, sx, sy;
    longint target, centre, step;
    logic [63:0] n;
    logic done;
    one = longint'(1) << fbits;
    if (off == 0) return {16'(OUT_ONE), 16'd0};
    if (off == 45) return {16'(HALF_ROOT2), 16'(HALF_ROOT2)};
    x0 = one; y0 = 0; x1 = 0; y1 = one; xc = 0; yc = 0;
    target = longint'(off) << 32;
    centre = longint'(45) << 32;
    step   = longint'(45) << 31;
    done   = 1'b0;
    for (int i = 0; i < iters; i++) begin
      if (target == centre) done = 1'b1;
      if (!done) begin
        sx = x0 + x1;
        sy = y0 + y1;
        n  = isqrt(64'(sx * sx) + 64'(sy * sy));
        if (n == 64'd0) n = 64'd1;
        xc = scaled_div(sx, n, fbits);
        yc = scaled_div(sy, n, fbits);
        if (target > centre) begin
          x0 = xc; y0 = yc; centre = centre + step;
        end else begin
          x1 = xc; y1 = yc; centre = centre - step;
        end
        step = step >>> 1;
      end
    end
    return {to_q14(xc, fbits), to_q14(yc, fbits)};
  endfunction

  function automatic logic [TABLE_DEPTH*32-1:0] build_table(input int iters,
                                                            input int fbits);
    logic [TABLE_DEPTH*32-1:0] t;
    t = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) t[k*32 +: 32] = entry(k, iters, fbits);
    return t;
  endfunction

endpackage

### rtl/scb_in_if.sv
// ----------------------------------------------------------------------------
// scb_in_if: angle input channel
// Valid/ready channel carrying one whole-degree angle per item.
// ----------------------------------------------------------------------------
interface scb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_deg;
  modport source (output valid, output angle_deg, input ready);
  modport sink (input valid, input angle_deg, output ready);
endinterface

### rtl/scb_out_if.sv
// ----------------------------------------------------------------------------
// scb_out_if: sine and cosine result channel
// Valid/ready channel carrying one Q2.14 sine and cosine pair per item.
// ----------------------------------------------------------------------------
interface scb_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sine;
  logic signed [15:0] cosine;
  modport source (output valid, output sine, output cosine, input ready);
  modport sink (input valid, input sine, input cosine, output ready);
endinterface

### rtl/scb_reduce.sv
// ----------------------------------------------------------------------------
// scb_reduce: angle reduction pipeline
// Three stages: bias and reciprocal multiply, remainder, quadrant split.
// ----------------------------------------------------------------------------
module scb_reduce (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  logic signed [15:0] angle_deg,
  output scb_pkg::red_t      red
);

  logic        v1, v2;
  logic [16:0] u1;
  logic [32:0] prod1;
  logic [8:0]  r2;
  logic [7:0]  q_est;
  logic [16:0] q_scaled;
  logic [16:0] u_next;
  logic        red_valid;
  logic [1:0]  red_quad;
  logic [6:0]  red_off;

  assign u_next   = 17'($signed({angle_deg[15], angle_deg}) + 17'(scb_pkg::OFFSET_BIAS));
  assign q_est    = prod1[scb_pkg::RECIP_SHIFT +: 8];
  assign q_scaled = 17'(q_est) * 17'(scb_pkg::MOD_BASE);
  assign red      = '{valid: red_valid, quad: red_quad, off: red_off};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      red_valid <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      red_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      u1    <= u_next;
      prod1 <= 33'(u_next) * 33'(scb_pkg::RECIP);
      r2    <= 9'(u1 - q_scaled);
      if (r2 >= 9'(3 * scb_pkg::QUAD_SPAN)) begin
        red_quad <= scb_pkg::QUAD_3;
        red_off  <= 7'(r2 - 9'(3 * scb_pkg::QUAD_SPAN));
      end else if (r2 >= 9'(2 * scb_pkg::QUAD_SPAN)) begin
        red_quad <= scb_pkg::QUAD_2;
        red_off  <= 7'(r2 - 9'(2 * scb_pkg::QUAD_SPAN));
      end else if (r2 >= 9'(scb_pkg::QUAD_SPAN)) begin
        red_quad <= scb_pkg::QUAD_1;
        red_off  <= 7'(r2 - 9'(scb_pkg::QUAD_SPAN));
      end else begin
        red_quad <= scb_pkg::QUAD_0;
        red_off  <= 7'(r2);
      end
    end
  end

endmodule

### rtl/scb_lookup.sv
// ----------------------------------------------------------------------------
// scb_lookup: first-quadrant table and quadrant rotation
// Reads the bisection result for the offset, then rotates it into place.
// ----------------------------------------------------------------------------
module scb_lookup #(
  parameter int ITERATIONS    = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  scb_pkg::red_t      red,
  output logic               out_valid,
  output logic signed [15:0] sine,
  output logic signed [15:0] cosine
);

  localparam logic [scb_pkg::TABLE_DEPTH*32-1:0] TBL =
    scb_pkg::build_table(ITERATIONS, FRACTION_BITS);

  logic              v4;
  logic [1:0]        quad4;
  logic signed [15:0] c4, s4;
  logic [31:0]       rd;

  always_comb begin
    rd = '0;
    for (int k = 0; k < scb_pkg::TABLE_DEPTH; k++) begin
      if (red.off == 7'(k)) rd = TBL[k*32 +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v4 <= red.valid;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      quad4 <= red.quad;
      c4    <= $signed(rd[31:16]);
      s4    <= $signed(rd[15:0]);
      case (quad4)
        scb_pkg::QUAD_0: begin
          cosine <= c4;
          sine   <= s4;
        end
        scb_pkg::QUAD_1: begin
          cosine <= -s4;
          sine   <= c4;
        end
        scb_pkg::QUAD_2: begin
          cosine <= -c4;
          sine   <= -s4;
        end
        default: begin
          cosine <= s4;
          sine   <= -c4;
        end
      endcase
    end
  end

endmodule

### rtl/sine_cosine_by_angle_bisection_top.sv
// ----------------------------------------------------------------------------
// sine_cosine_by_angle_bisection_top: sine and cosine of a whole-degree angle
// Five-stage pipeline giving Q2.14 sine and cosine for any 16-bit angle.
// ----------------------------------------------------------------------------
// The block takes one angle per clock unless the output stalls, and returns
// its sine and cosine. The angle is reduced modulo 360 by a reciprocal
// multiply, split into quadrant and offset, and the offset reads a 90-entry
// table holding the bisection result, built at elaboration from ITERATIONS
// and FRACTION_BITS; the quadrant then rotates the pair into place. The
// pipeline moves as a whole, so a stalled output holds every stage.
module sine_cosine_by_angle_bisection_top #(
  parameter int ITERATIONS    = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic             clk,
  input  logic             rst,
  scb_in_if.sink           angle,
  scb_out_if.source        result
);

  logic          advance;
  scb_pkg::red_t red;

  assign advance     = !result.valid || result.ready;
  assign angle.ready = advance;

  scb_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (angle.valid),
    .angle_deg (angle.angle_deg),
    .red       (red)
  );

  scb_lookup #(
    .ITERATIONS    (ITERATIONS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_lookup (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .red       (red),
    .out_valid (result.valid),
    .sine      (result.sine),
    .cosine    (result.cosine)
  );

  a_sine_range : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.sine <= 16'sd16384 && result.sine >= -16'sd16384))
    else $error("sine out of range");

  a_cosine_range : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.cosine <= 16'sd16384 && result.cosine >= -16'sd16384))
    else $error("cosine out of range");

  a_off_range : assert property (@(posedge clk) disable iff (rst)
    red.valid |-> red.off < 7'(scb_pkg::TABLE_DEPTH))
    else $error("quadrant offset out of range");

endmodule
